[sv/utflcd_pkg.sv]
// Shared types and the code point to display character table for the UTF-8 converter.
package utflcd_pkg;

   // Widths fixed by the interface
   localparam int BYTE_W   = 8;
   localparam int CAP_W    = 16;
   localparam int CODE_W   = 8;
   localparam int OCOUNT_W = 16;
   localparam int ACCUM_W  = 31;
   localparam int PEND_W   = 3;

   // One decoded result beat
   typedef struct packed {
      logic [CODE_W-1:0]   char_code;
      logic                char_valid;
      logic                last;
      logic                status;
      logic [OCOUNT_W-1:0] char_count;
   } result_type;

   // Table lookup answer
   typedef struct packed {
      logic              hit;
      logic [CODE_W-1:0] code;
   } map_type;

   // Code point to display code: 0x20 to 0x7D (except backslash) maps to itself,
   // a fixed list of other points maps through the table, the rest misses.
   function automatic map_type map_lookup(input logic [ACCUM_W-1:0] cp);
      map_type r;
      logic    upper_zero;
      r          = '0;
      upper_zero = (cp[ACCUM_W-1:16] == '0);
      if (cp >= ACCUM_W'(32'h20) && cp <= ACCUM_W'(32'h7D) && cp != ACCUM_W'(32'h5C)) begin
         r.hit  = 1'b1;
         r.code = cp[7:0];
      end else if (upper_zero) begin
         r.hit = 1'b1;
         case (cp[15:0])
            16'h00A7: r.code = 8'h12;
            16'h00B6: r.code = 8'h13;
            16'h00A9: r.code = 8'h0F;
            16'h00AE: r.code = 8'h0E;
            16'h00BD: r.code = 8'hF5;
            16'h00BC: r.code = 8'hF6;
            16'h00D7: r.code = 8'hF7;
            16'h00F7: r.code = 8'hF8;
            16'h2264: r.code = 8'hF9;
            16'h2265: r.code = 8'hFA;
            16'h226A: r.code = 8'hFB;
            16'h226B: r.code = 8'hFC;
            16'h2260: r.code = 8'hFD;
            16'h221A: r.code = 8'hFE;
            16'h00C7: r.code = 8'h80;
            16'h00FC: r.code = 8'h81;
            16'h00E9: r.code = 8'h82;
            16'h00E2: r.code = 8'h83;
            16'h00E4: r.code = 8'h84;
            16'h00E0: r.code = 8'h85;
            16'h0227: r.code = 8'h86;
            16'h00E7: r.code = 8'h87;
            16'h00EA: r.code = 8'h88;
            16'h00EB: r.code = 8'h89;
            16'h00E8: r.code = 8'h8A;
            16'h00EF: r.code = 8'h8B;
            16'h00EE: r.code = 8'h8C;
            16'h00EC: r.code = 8'h8D;
            16'h00C4: r.code = 8'h8E;
            16'h00C2: r.code = 8'h8F;
            16'h00C9: r.code = 8'h90;
            16'h00E6: r.code = 8'h91;
            16'h00C6: r.code = 8'h92;
            16'h00F4: r.code = 8'h93;
            16'h00F6: r.code = 8'h94;
            16'h00F2: r.code = 8'h95;
            16'h00FB: r.code = 8'h96;
            16'h00F9: r.code = 8'h97;
            16'h00FF: r.code = 8'h98;
            16'h00D6: r.code = 8'h99;
            16'h00DC: r.code = 8'h9A;
            16'h00F1: r.code = 8'h9B;
            16'h00D1: r.code = 8'h9C;
            16'h00AA: r.code = 8'h9D;
            16'h00BA: r.code = 8'h9E;
            16'h00BF: r.code = 8'h9F;
            16'h00E1: r.code = 8'hE0;
            16'h00ED: r.code = 8'hE1;
            16'h00F3: r.code = 8'hE2;
            16'h00FA: r.code = 8'hE3;
            16'h00A2: r.code = 8'hE4;
            16'h00A3: r.code = 8'hE5;
            16'h00A5: r.code = 8'hE6;
            16'h00A1: r.code = 8'hE9;
            16'h00C3: r.code = 8'hEA;
            16'h00E3: r.code = 8'hEB;
            16'h00D5: r.code = 8'hEC;
            16'h00F5: r.code = 8'hED;
            16'h00D8: r.code = 8'hEE;
            16'h00F8: r.code = 8'hEF;
            16'h0393: r.code = 8'h14;
            16'h0394: r.code = 8'h15;
            16'h0398: r.code = 8'h16;
            16'h039B: r.code = 8'h17;
            16'h039E: r.code = 8'h18;
            16'h03A0: r.code = 8'h19;
            16'h03A3: r.code = 8'h1A;
            16'h03D2: r.code = 8'h1B;
            16'h03A6: r.code = 8'h1C;
            16'h03A8: r.code = 8'h1D;
            16'h03A9: r.code = 8'h1E;
            16'h03B1: r.code = 8'h1F;
            16'h250C: r.code = 8'h09;
            16'h2510: r.code = 8'h0A;
            16'h2514: r.code = 8'h0B;
            16'h2518: r.code = 8'h0C;
            16'h2500: r.code = 8'hFF;
            default: begin
               r.hit  = 1'b0;
               r.code = '0;
            end
         endcase
      end
      return r;
   endfunction

endpackage

[sv/utflcd_decoder.sv]
// UTF-8 sequence state, table mapping and per-string character counting.
module utflcd_decoder #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  logic [utflcd_pkg::BYTE_W-1:0]       in_byte,
   input  logic [utflcd_pkg::CAP_W-1:0]        capacity,
   output logic                                res_valid,
   output utflcd_pkg::result_type              res
);

   logic [utflcd_pkg::PEND_W-1:0]  pending_ff, pending_in;
   logic [utflcd_pkg::ACCUM_W-1:0] accum_ff, accum_in;
   logic [COUNT_BITS-1:0]          count_ff, count_in;
   logic                           discard_ff, discard_in;

   logic                           finish_req;
   logic [utflcd_pkg::ACCUM_W-1:0] finish_cp;
   logic [utflcd_pkg::ACCUM_W-1:0] accum_shift;
   logic [utflcd_pkg::PEND_W-1:0]  pending_dec;
   logic                           redecode;
   utflcd_pkg::map_type            map_hit;
   logic [COUNT_BITS-1:0]          count_inc;
   logic                           reach_cap;

   assign accum_shift = {accum_ff[utflcd_pkg::ACCUM_W-7:0], in_byte[5:0]};
   assign pending_dec = pending_ff - utflcd_pkg::PEND_W'(1);

   // Sequence assembly and lead byte decode
   always_comb begin
      pending_in = pending_ff;
      accum_in   = accum_ff;
      count_in   = count_ff;
      discard_in = discard_ff;
      finish_req = 1'b0;
      finish_cp  = '0;
      redecode   = 1'b0;
      res_valid  = 1'b0;
      res        = '0;

      if (discard_ff) begin
         // skip up to the string end
         if (in_byte == '0) begin
            discard_in = 1'b0;
            count_in   = '0;
            pending_in = '0;
            accum_in   = '0;
         end
      end else begin
         redecode = 1'b1;
         if (pending_ff != '0) begin
            if (in_byte[7:6] == 2'b10) begin
               redecode   = 1'b0;
               accum_in   = accum_shift;
               pending_in = pending_dec;
               if (pending_dec == '0) begin
                  finish_req = 1'b1;
                  finish_cp  = accum_shift;
               end
            end else begin
               // broken sequence: drop it, treat this byte as a lead
               pending_in = '0;
               accum_in   = '0;
            end
         end
         if (redecode) begin
            if (in_byte == '0) begin
               res_valid      = 1'b1;
               res.last       = 1'b1;
               res.char_count = 16'(32'(count_ff));
               count_in       = '0;
            end else if (in_byte[7] == 1'b0) begin
               finish_req = 1'b1;
               finish_cp  = utflcd_pkg::ACCUM_W'(in_byte);
            end else if (in_byte[7:5] == 3'b110) begin
               accum_in   = utflcd_pkg::ACCUM_W'(in_byte[4:0]);
               pending_in = utflcd_pkg::PEND_W'(1);
            end else if (in_byte[7:4] == 4'b1110) begin
               accum_in   = utflcd_pkg::ACCUM_W'(in_byte[3:0]);
               pending_in = utflcd_pkg::PEND_W'(2);
            end else if (in_byte[7:3] == 5'b11110) begin
               accum_in   = utflcd_pkg::ACCUM_W'(in_byte[2:0]);
               pending_in = utflcd_pkg::PEND_W'(3);
            end else if (in_byte[7:2] == 6'b111110) begin
               accum_in   = utflcd_pkg::ACCUM_W'(in_byte[1:0]);
               pending_in = utflcd_pkg::PEND_W'(4);
            end else if (in_byte[7:1] == 7'b1111110) begin
               accum_in   = utflcd_pkg::ACCUM_W'(in_byte[0]);
               pending_in = utflcd_pkg::PEND_W'(5);
            end
         end
      end

      // Completed code point: map, count, check capacity
      map_hit   = utflcd_pkg::map_lookup(finish_cp);
      count_inc = (count_ff != '1) ? count_ff + COUNT_BITS'(1) : count_ff;
      reach_cap = (33'(count_inc) >= 33'(capacity)) || (count_inc == '1);
      if (finish_req && map_hit.hit) begin
         count_in       = count_inc;
         discard_in     = reach_cap;
         res_valid      = 1'b1;
         res.char_code  = map_hit.code;
         res.char_valid = 1'b1;
         res.last       = reach_cap;
         res.status     = reach_cap;
         res.char_count = 16'(32'(count_inc));
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         accum_ff   <= '0;
         count_ff   <= '0;
         discard_ff <= 1'b0;
      end else if (fire) begin
         pending_ff <= pending_in;
         accum_ff   <= accum_in;
         count_ff   <= count_in;
         discard_ff <= discard_in;
      end
   end

endmodule

[sv/utf8_to_lcd_charset_stream.sv]
// Top level: UTF-8 byte stream to display charset converter with input and result registers.
// One UTF-8 byte per req beat, at most one rsp beat per byte; a new byte is taken every
// cycle while the result register is free or being drained. Each byte passes the
// input register, then sequence decode, table compare and counting in one pass into the
// result register. A byte that completes no mapped character (continuation, bad lead,
// unmapped point, discarded tail) gives no rsp beat. A zero byte ends the string with a
// last beat; the beat that reaches csr_out_capacity is last with status 1, and bytes up
// to the next zero are then skipped silently. csr_ready is always high.
module utf8_to_lcd_charset_stream #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [utflcd_pkg::BYTE_W-1:0]       req_in_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [utflcd_pkg::CODE_W-1:0]       rsp_char_code,
   output logic                                rsp_char_valid,
   output logic                                rsp_last,
   output logic                                rsp_status,
   output logic [utflcd_pkg::OCOUNT_W-1:0]     rsp_char_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [utflcd_pkg::CAP_W-1:0]        csr_out_capacity
);

   logic [utflcd_pkg::CAP_W-1:0]  cap_ff;
   logic                          in_valid_ff, in_valid_in;
   logic [utflcd_pkg::BYTE_W-1:0] in_byte_ff;
   logic                          out_valid_ff, out_valid_in;
   utflcd_pkg::result_type        out_ff;
   logic                          out_free;
   logic                          fire;
   logic                          req_take;
   logic                          dec_valid;
   utflcd_pkg::result_type        dec_res;

   assign csr_ready = 1'b1;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= utflcd_pkg::CAP_W'(16);
      end else if (csr_valid) begin
         cap_ff <= csr_out_capacity;
      end
   end

   // Handshake: decode when the result register can take a beat
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = fire && dec_valid;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
   end

   utflcd_decoder #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decoder (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .in_byte   (in_byte_ff),
      .capacity  (cap_ff),
      .res_valid (dec_valid),
      .res       (dec_res)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && fire && dec_valid) begin
         out_ff <= dec_res;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_char_code  = out_ff.char_code;
   assign rsp_char_valid = out_ff.char_valid;
   assign rsp_last       = out_ff.last;
   assign rsp_status     = out_ff.status;
   assign rsp_char_count = out_ff.char_count;

endmodule

[verif/tb_utf8_to_lcd_charset_stream.sv]
// Self-checking testbench for the UTF-8 to display charset stream converter.
module tb_utf8_to_lcd_charset_stream;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0]  BYTE_NUL    = 8'h00;
   localparam logic        STATUS_DONE = 1'b0;
   localparam logic        STATUS_FULL = 1'b1;
   localparam logic [15:0] COUNT_SAT   = 16'hFFFF;
   localparam logic [15:0] CAP_RESET   = 16'd16;
   localparam int          PIPE_CYCLES = 4;
   localparam int          MAP_LEN     = 77;

   // Code points and display codes of the non-ASCII table, first entry at the top
   localparam logic [MAP_LEN*16-1:0] MAP_POINTS = {
      16'h00A7, 16'h00B6, 16'h00A9, 16'h00AE, 16'h00BD, 16'h00BC, 16'h00D7, 16'h00F7,
      16'h2264, 16'h2265, 16'h226A, 16'h226B, 16'h2260, 16'h221A,
      16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h0227, 16'h00E7,
      16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C2,
      16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
      16'h00FF, 16'h00D6, 16'h00DC, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA, 16'h00BF,
      16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00A2, 16'h00A3, 16'h00A5, 16'h00A1,
      16'h00C3, 16'h00E3, 16'h00D5, 16'h00F5, 16'h00D8, 16'h00F8,
      16'h0393, 16'h0394, 16'h0398, 16'h039B, 16'h039E, 16'h03A0, 16'h03A3, 16'h03D2,
      16'h03A6, 16'h03A8, 16'h03A9, 16'h03B1,
      16'h250C, 16'h2510, 16'h2514, 16'h2518, 16'h2500
   };
   localparam logic [MAP_LEN*8-1:0] MAP_CODES = {
      8'h12, 8'h13, 8'h0F, 8'h0E, 8'hF5, 8'hF6, 8'hF7, 8'hF8,
      8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE,
      8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
      8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F,
      8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97,
      8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'h9F,
      8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE9,
      8'hEA, 8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hEF,
      8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B,
      8'h1C, 8'h1D, 8'h1E, 8'h1F,
      8'h09, 8'h0A, 8'h0B, 8'h0C, 8'hFF
   };

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [utflcd_pkg::BYTE_W-1:0]       req_in_byte;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [utflcd_pkg::CODE_W-1:0]       rsp_char_code;
   logic                                rsp_char_valid;
   logic                                rsp_last;
   logic                                rsp_status;
   logic [utflcd_pkg::OCOUNT_W-1:0]     rsp_char_count;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [utflcd_pkg::CAP_W-1:0]        csr_out_capacity;

   // Predictor state
   logic [utflcd_pkg::CAP_W-1:0]    cap_setting  = CAP_RESET;
   logic [utflcd_pkg::PEND_W-1:0]   cont_left    = '0;
   logic [utflcd_pkg::ACCUM_W-1:0]  code_acc     = '0;
   logic [utflcd_pkg::OCOUNT_W-1:0] char_total   = '0;
   logic                            in_discard   = 1'b0;

   utflcd_pkg::result_type expected_chars[$];
   int                     mismatch_count = 0;
   int                     sent_bytes     = 0;
   bit                     idle_on        = 1'b1;

   utf8_to_lcd_charset_stream #(.COUNT_BITS(16)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_char_code    (rsp_char_code),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status),
      .rsp_char_count   (rsp_char_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_out_capacity (csr_out_capacity)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Code point to display code; hit is 0 for points outside the charset
   function automatic bit lookup_display_code(input logic [utflcd_pkg::ACCUM_W-1:0] cp,
                                              output logic [7:0] code);
      int i;
      code = '0;
      if (cp >= 31'h20 && cp <= 31'h7D && cp != 31'h5C) begin
         code = cp[7:0];
         return 1'b1;
      end
      if (cp[utflcd_pkg::ACCUM_W-1:16] != '0) return 1'b0;
      for (i = 0; i < MAP_LEN; i++) begin
         if (cp[15:0] == MAP_POINTS[(MAP_LEN-1-i)*16 +: 16]) begin
            code = MAP_CODES[(MAP_LEN-1-i)*8 +: 8];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // A completed point: count it, flag the string full when capacity is hit
   function automatic bit emit_point(input logic [utflcd_pkg::ACCUM_W-1:0] cp,
                                     output utflcd_pkg::result_type r);
      logic [7:0] code;
      r = '0;
      if (!lookup_display_code(cp, code)) return 1'b0;
      if (char_total != COUNT_SAT) char_total++;
      r.char_code  = code;
      r.char_valid = 1'b1;
      r.char_count = char_total;
      r.status     = STATUS_DONE;
      if (char_total >= cap_setting || char_total == COUNT_SAT) begin
         in_discard = 1'b1;
         r.last     = 1'b1;
         r.status   = STATUS_FULL;
      end
      return 1'b1;
   endfunction

   // One input byte through the decoder; returns 1 when a beat is expected
   function automatic bit decode_byte(input logic [7:0] b,
                                      output utflcd_pkg::result_type r);
      r = '0;
      if (in_discard) begin
         if (b == BYTE_NUL) begin
            in_discard = 1'b0;
            char_total = '0;
            cont_left  = '0;
            code_acc   = '0;
         end
         return 1'b0;
      end
      if (cont_left != 0) begin
         if (b[7:6] == 2'b10) begin
            code_acc  = {code_acc[utflcd_pkg::ACCUM_W-7:0], b[5:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == 0) return emit_point(code_acc, r);
            return 1'b0;
         end
         // broken sequence: byte is re-decoded as a lead
         cont_left = '0;
         code_acc  = '0;
      end
      if (b == BYTE_NUL) begin
         r.last     = 1'b1;
         r.status   = STATUS_DONE;
         r.char_count = char_total;
         char_total = '0;
         return 1'b1;
      end
      if (!b[7]) return emit_point({23'd0, b}, r);
      casez (b)
         8'b110?????: begin code_acc = 31'(b[4:0]); cont_left = 3'd1; end
         8'b1110????: begin code_acc = 31'(b[3:0]); cont_left = 3'd2; end
         8'b11110???: begin code_acc = 31'(b[2:0]); cont_left = 3'd3; end
         8'b111110??: begin code_acc = 31'(b[1:0]); cont_left = 3'd4; end
         8'b1111110?: begin code_acc = 31'(b[0]);   cont_left = 3'd5; end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // Send one byte beat; entered and left at a falling edge with valid still high
   task automatic send_byte(input logic [7:0] b);
      utflcd_pkg::result_type r;
      int                     gap;
      if (idle_on && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      sent_bytes++;
      if (decode_byte(b, r)) expected_chars.push_back(r);
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected beat is back and the pipe is empty
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_capacity(input logic [utflcd_pkg::CAP_W-1:0] value);
      drain_results();
      csr_valid        <= 1'b1;
      csr_out_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      cap_setting = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Bytes 0..keep-1 of the n-byte encoding of cp (n may be overlong)
   task automatic send_point(input logic [utflcd_pkg::ACCUM_W-1:0] cp, input int n,
                             input int keep);
      logic [7:0] b;
      int         i;
      for (i = 0; i < keep; i++) begin
         if (i == 0 && n == 1)
            b = {1'b0, cp[6:0]};
         else if (i == 0)
            b = 8'(8'hFF << (8 - n)) | 8'((cp >> (6 * (n - 1))) & ((31'd1 << (7 - n)) - 1));
         else
            b = 8'h80 | 8'((cp >> (6 * (n - 1 - i))) & 31'h3F);
         send_byte(b);
      end
   endtask

   function automatic int utf8_len(input logic [utflcd_pkg::ACCUM_W-1:0] cp);
      if (cp < 31'h80)      return 1;
      if (cp < 31'h800)     return 2;
      if (cp < 31'h10000)   return 3;
      if (cp < 31'h200000)  return 4;
      if (cp < 31'h4000000) return 5;
      return 6;
   endfunction

   // Result checker
   initial begin
      utflcd_pkg::result_type got;
      utflcd_pkg::result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.char_code  = rsp_char_code;
            got.char_valid = rsp_char_valid;
            got.last       = rsp_last;
            got.status     = rsp_status;
            got.char_count = rsp_char_count;
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected beat: code=%h valid=%b last=%b status=%b count=%0d",
                           got.char_code, got.char_valid, got.last, got.status,
                           got.char_count);
            end else begin
               want = expected_chars.pop_front();
               if (got.char_code !== want.char_code || got.char_valid !== want.char_valid ||
                   got.last !== want.last || got.status !== want.status ||
                   got.char_count !== want.char_count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp code=%h valid=%b last=%b status=%b count=%0d",
                              want.char_code, want.char_valid, want.last, want.status,
                              want.char_count, " | got code=%h valid=%b last=%b status=%b",
                              got.char_code, got.char_valid, got.last, got.status,
                              " count=%0d", got.char_count);
               end
            end
         end
      end
   end

   // Receiver back-pressure: stall bursts mixed with clear stretches
   initial begin
      int  stall_left;
      int  run_left;
      bit  next_stall;
      stall_left = 0;
      run_left   = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            next_stall = 1'b1;
            stall_left--;
         end else if (run_left > 0 || !idle_on) begin
            next_stall = 1'b0;
            if (run_left > 0) run_left--;
         end else if ($urandom_range(0, 1) == 1) begin
            next_stall = 1'b1;
            stall_left = $urandom_range(1, 19) - 1;
         end else begin
            next_stall = 1'b0;
            run_left   = $urandom_range(0, 30);
         end
         rsp_stall <= next_stall;
      end
   end

   // Every lead length, bad leads, unmapped points and broken sequences
   task automatic test_directed_decode();
      send_byte(8'h20);
      send_byte(8'h7D);
      send_byte(8'h5C);
      send_byte(8'h7F);
      send_point(31'h00A7, 2, 2);
      send_point(31'h2500, 3, 3);
      send_point(31'h0041, 4, 4);
      send_point(31'h7FFFFFFF, 6, 6);
      send_byte(8'hF8);
      send_byte(8'h41);
      send_byte(8'h80);
      send_byte(8'hFE);
      send_byte(8'hFF);
      send_byte(8'hE2);
      send_byte(BYTE_NUL);
   endtask

   // Capacity hit mid-string, exactly at string end, and at zero
   task automatic test_capacity_limits();
      write_capacity(16'd1);
      send_byte(8'h41);
      send_byte(8'h42);
      send_byte(BYTE_NUL);
      write_capacity(16'd2);
      send_byte(8'h41);
      send_point(31'h03B1, 2, 2);
      send_byte(BYTE_NUL);
      write_capacity(16'd0);
      send_byte(8'h43);
      send_byte(BYTE_NUL);
   endtask

   // Mostly well-formed strings with random content, some noise and broken sequences
   task automatic send_random_string();
      int                             n_chars;
      int                             k;
      int                             i;
      int                             n;
      logic [utflcd_pkg::ACCUM_W-1:0] cp;
      n_chars = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      for (i = 0; i < n_chars; i++) begin
         k = $urandom_range(0, 99);
         if (k < 50)
            cp = 31'($urandom_range(32'h20, 32'h7E));
         else if (k < 86 && k >= 80)
            cp = 31'($urandom >> $urandom_range(0, 31));
         else
            cp = 31'(MAP_POINTS[(MAP_LEN-1-$urandom_range(0, MAP_LEN-1))*16 +: 16]);
         n = utf8_len(cp);
         if ($urandom_range(0, 9) == 0) n = $urandom_range(n, 6);
         if (k >= 86 && k < 92)
            send_byte(8'($urandom_range(0, 255)));
         else if (k >= 92 && n > 1)
            send_point(cp, n, $urandom_range(1, n - 1));
         else
            send_point(cp, n, n);
      end
      send_byte(BYTE_NUL);
   endtask

   task automatic test_random_strings();
      int phase;
      int target;
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_capacity(16'd1);
            1: write_capacity(16'($urandom_range(2, 8)));
            2: write_capacity(16'($urandom_range(9, 40)));
            3: write_capacity(16'hFFFF);
            default: write_capacity(16'($urandom_range(1, 6)));
         endcase
         target = sent_bytes + 90;
         while (sent_bytes < target) send_random_string();
      end
   endtask

   // Strings back to back with no idling on either side
   task automatic test_back_to_back();
      int target;
      write_capacity(16'($urandom_range(3, 12)));
      target = sent_bytes + 30;
      while (sent_bytes < target) send_random_string();
   endtask

   // Test sequence
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_in_byte      = '0;
      csr_valid        = 1'b0;
      csr_out_capacity = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_decode();
      test_capacity_limits();
      test_random_strings();
      idle_on = 1'b0;
      test_back_to_back();
      drain_results();
      if (expected_chars.size() != 0) mismatch_count++;
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
